// ===== rtl/gvc_pkg.sv =====
package gvc_pkg;

    // item field widths
    localparam int POINT_W = 16;
    localparam int COST_W  = 16;
    localparam int PAN_W   = 15;
    localparam int TILT_W  = 14;

    // datapath widths
    localparam int DIFF_W = 17;
    localparam int PROD_W = 33;
    localparam int ACC_W  = 35;
    localparam int LOC_W  = 27;
    localparam int ABS_W  = 26;
    localparam int SQ_W   = 53;
    localparam int ROOT_W = 27;
    localparam int SQ_STEPS = 27;
    localparam int CW     = 31;
    localparam int ESUM_W = 17;

    localparam int OUT_FRAC = 13;
    localparam logic [PAN_W-1:0]  PAN_MAX  = 15'd25736;
    localparam logic [TILT_W-1:0] TILT_MAX = 14'd12868;
    localparam logic [COST_W-1:0] COST_MAX = 16'hFFFF;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam longint ATAN_Q30 [24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
    };

    // register reset values
    localparam logic [47:0] ROT0_RST = 48'h4000_0000_0000;
    localparam logic [47:0] ROT1_RST = 48'h0000_4000_0000;
    localparam logic [47:0] ROT2_RST = 48'h0000_0000_4000;
    localparam logic [14:0] TOL_RST  = 15'd2458;
    localparam logic [15:0] GAIN_RST = 16'd16851;

    typedef enum logic [2:0] {
        REG_ROT0 = 3'd0,
        REG_ROT1 = 3'd1,
        REG_ROT2 = 3'd2,
        REG_POS  = 3'd3,
        REG_TPAN = 3'd4,
        REG_TTLT = 3'd5,
        REG_GAIN = 3'd6
    } t_reg_idx;

    // Q.30 angle rounded half up to frac bits
    function automatic longint q30_to_ang(longint t, int frac);
        int s;
        s = 30 - frac;
        return (t + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

endpackage

// ===== rtl/gvc_if.sv =====
interface gvc_point_if;
    import gvc_pkg::*;
    logic valid;
    logic ready;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
    logic signed [POINT_W-1:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface gvc_cost_if;
    import gvc_pkg::*;
    logic valid;
    logic ready;
    logic [COST_W-1:0] cost;
    logic [PAN_W-1:0]  pan_angle;
    logic [TILT_W-1:0] tilt_angle;
    logic              at_origin;

    modport source (output valid, cost, pan_angle, tilt_angle, at_origin, input ready);
    modport sink   (input valid, cost, pan_angle, tilt_angle, at_origin, output ready);
endinterface

// ===== rtl/gaze_visibility_cost_core.sv =====
// channel  | dir | handshake     | payload
// i_pt     | in  | valid / ready | point_x, point_y, point_z (signed Q7.8)
// o_res    | out | valid / ready | cost, pan_angle, tilt_angle, at_origin
// apb      | in  | psel/penable  | 64-bit registers at 8*index
//
// one item per cycle unless the output stalls; the chain runs through
// the 27 root cells and the CORDIC cells that follow them
// i_rst_n clears the valid line and the output valid flag, and loads the registers' reset values
// a stalled output freezes the whole chain; i_pt.ready is low only during such a stall
module gaze_visibility_cost_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int ANGLE_WIDTH   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gvc_point_if.sink   i_pt,
    gvc_cost_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import gvc_pkg::*;

    localparam int FRAC = ANGLE_WIDTH - 3;
    localparam int ZW   = ANGLE_WIDTH + 1;
    localparam int SBW  = 3 * ABS_W + 2;
    localparam int LAT  = 6 + SQ_STEPS + CORDIC_STAGES + 2;
    localparam int SH_R = (FRAC > OUT_FRAC) ? FRAC - OUT_FRAC : 0;
    localparam int SH_L = (FRAC > OUT_FRAC) ? 0 : OUT_FRAC - FRAC;
    localparam logic [31:0] RND = (SH_R > 0) ? (32'd1 << (SH_R - 1)) : 32'd0;
    localparam logic signed [ZW-1:0] HALF_PI_A = ZW'(q30_to_ang(HALF_PI_Q30, FRAC));
    localparam logic signed [ZW-1:0] PI_A      = ZW'(q30_to_ang(PI_Q30, FRAC));

    // configuration
    logic [47:0] r_rot [3];
    logic [47:0] r_pos;
    logic [14:0] r_tol_pan;
    logic [14:0] r_tol_tilt;
    logic [15:0] r_gain;
    t_reg_idx    reg_idx;

    assign reg_idx = t_reg_idx'(paddr[5:3]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROT0_RST;
            r_rot[1]   <= ROT1_RST;
            r_rot[2]   <= ROT2_RST;
            r_pos      <= '0;
            r_tol_pan  <= TOL_RST;
            r_tol_tilt <= TOL_RST;
            r_gain     <= GAIN_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ROT0: r_rot[0]   <= pwdata[47:0];
                REG_ROT1: r_rot[1]   <= pwdata[47:0];
                REG_ROT2: r_rot[2]   <= pwdata[47:0];
                REG_POS:  r_pos      <= pwdata[47:0];
                REG_TPAN: r_tol_pan  <= pwdata[14:0];
                REG_TTLT: r_tol_tilt <= pwdata[14:0];
                REG_GAIN: r_gain     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROT0: prdata = {16'd0, r_rot[0]};
            REG_ROT1: prdata = {16'd0, r_rot[1]};
            REG_ROT2: prdata = {16'd0, r_rot[2]};
            REG_POS:  prdata = {16'd0, r_pos};
            REG_TPAN: prdata = {49'd0, r_tol_pan};
            REG_TTLT: prdata = {49'd0, r_tol_tilt};
            REG_GAIN: prdata = {48'd0, r_gain};
            default:  prdata = '0;
        endcase
    end

    // flow control
    logic           adv;
    logic [LAT-1:0] r_v;
    logic           r_out_valid;

    assign adv        = !r_out_valid || o_res.ready;
    assign i_pt.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v         <= {r_v[LAT-2:0], i_pt.valid};
            r_out_valid <= r_v[LAT-1];
        end
    end

    // head frame transform
    logic signed [DIFF_W-1:0] r_d   [3];
    logic signed [PROD_W-1:0] r_p   [3][3];
    logic signed [ACC_W-1:0]  r_acc [3];
    logic signed [POINT_W-1:0] pt   [3];

    assign pt[0] = i_pt.point_x;
    assign pt[1] = i_pt.point_y;
    assign pt[2] = i_pt.point_z;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_d[j] <= DIFF_W'(pt[j]) - DIFF_W'($signed(r_pos[47-16*j -: 16]));
            end
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    // R transposed: entry (row j, column i)
                    r_p[i][j] <= PROD_W'($signed(r_rot[j][47-16*i -: 16])) * PROD_W'(r_d[j]);
                end
                r_acc[i] <= ACC_W'(r_p[i][0]) + ACC_W'(r_p[i][1]) + ACC_W'(r_p[i][2]);
            end
        end
    end

    // magnitudes, squares
    logic signed [LOC_W-1:0] loc [3];
    logic [LOC_W-1:0]        loc_abs [3];
    logic [ABS_W-1:0]        r_ax, r_ay, r_az;
    logic                    r_neg4, r_org4;
    logic [2*ABS_W-1:0]      r_sqx, r_sqy;
    logic [SQ_W-1:0]         r_n;
    logic [SBW-1:0]          r_sb5, r_sb6;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            loc[i]     = r_acc[i][ACC_W-1:8];
            loc_abs[i] = loc[i][LOC_W-1] ? LOC_W'(-loc[i]) : LOC_W'(loc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax   <= loc_abs[0][ABS_W-1:0];
            r_ay   <= loc_abs[1][ABS_W-1:0];
            r_az   <= loc_abs[2][ABS_W-1:0];
            r_neg4 <= loc[0][LOC_W-1];
            r_org4 <= (r_acc[0] == '0) && (r_acc[1] == '0) && (r_acc[2] == '0);
            r_sqx  <= (2*ABS_W)'(r_ax) * (2*ABS_W)'(r_ax);
            r_sqy  <= (2*ABS_W)'(r_ay) * (2*ABS_W)'(r_ay);
            r_sb5  <= {r_ax, r_ay, r_az, r_neg4, r_org4};
            r_n    <= SQ_W'(r_sqx) + SQ_W'(r_sqy);
            r_sb6  <= r_sb5;
        end
    end

    // root cells
    logic [SQ_W-1:0] sq_n [SQ_STEPS+1];
    logic [SQ_W-1:0] sq_r [SQ_STEPS+1];
    logic [SBW-1:0]  r_sb [SQ_STEPS];

    assign sq_n[0] = r_n;
    assign sq_r[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        gvc_sqrt_cell #(.B_SHIFT(2 * (SQ_STEPS - 1 - k))) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_n   (sq_n[k]),
            .i_r   (sq_r[k]),
            .o_n   (sq_n[k+1]),
            .o_r   (sq_r[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sb[0] <= r_sb6;
            for (int k = 1; k < SQ_STEPS; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // angle cells
    logic [ABS_W-1:0] sx, sy, sz;
    logic             sneg, sorg;
    logic signed [CW-1:0] pan_x [CORDIC_STAGES+1];
    logic signed [CW-1:0] pan_y [CORDIC_STAGES+1];
    logic signed [ZW-1:0] pan_z [CORDIC_STAGES+1];
    logic signed [CW-1:0] tlt_x [CORDIC_STAGES+1];
    logic signed [CW-1:0] tlt_y [CORDIC_STAGES+1];
    logic signed [ZW-1:0] tlt_z [CORDIC_STAGES+1];
    logic [1:0]           r_fl [CORDIC_STAGES];

    assign {sx, sy, sz, sneg, sorg} = r_sb[SQ_STEPS-1];
    assign pan_x[0] = CW'(sx);
    assign pan_y[0] = CW'(sy);
    assign pan_z[0] = '0;
    assign tlt_x[0] = CW'(sq_r[SQ_STEPS][ROOT_W-1:0]);
    assign tlt_y[0] = CW'(sz);
    assign tlt_z[0] = '0;

    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
        gvc_cordic_cell #(.STAGE(s), .FRAC(FRAC), .ZW(ZW)) u_pan (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (pan_x[s]),
            .i_y   (pan_y[s]),
            .i_z   (pan_z[s]),
            .o_x   (pan_x[s+1]),
            .o_y   (pan_y[s+1]),
            .o_z   (pan_z[s+1])
        );
        gvc_cordic_cell #(.STAGE(s), .FRAC(FRAC), .ZW(ZW)) u_tilt (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (tlt_x[s]),
            .i_y   (tlt_y[s]),
            .i_z   (tlt_z[s]),
            .o_x   (tlt_x[s+1]),
            .o_y   (tlt_y[s+1]),
            .o_z   (tlt_z[s+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fl[0] <= {sneg, sorg};
            for (int s = 1; s < CORDIC_STAGES; s++) begin
                r_fl[s] <= r_fl[s-1];
            end
        end
    end

    // angle format, dead zone, gain
    function automatic logic [31:0] ang_out(input logic signed [ZW-1:0] a);
        logic [31:0] v;
        v = 32'(unsigned'(a));
        if (SH_R > 0) begin
            return (v + RND) >> SH_R;
        end
        return v << SH_L;
    endfunction

    function automatic logic signed [ZW-1:0] clamp_q(input logic signed [ZW-1:0] z);
        if (z < 0) begin
            return '0;
        end
        if (z > HALF_PI_A) begin
            return HALF_PI_A;
        end
        return z;
    endfunction

    logic signed [ZW-1:0] pan_a, tilt_a;
    logic [31:0]          pan_w, tilt_w;
    logic [PAN_W-1:0]     pan_o;
    logic [TILT_W-1:0]    tilt_o;
    logic [PAN_W-1:0]     ep;
    logic [PAN_W-1:0]     et;
    logic                 fneg, forg;

    logic [ESUM_W-1:0]    r_esum;
    logic [PAN_W-1:0]     r_pan1, r_pan2, r_pan_q;
    logic [TILT_W-1:0]    r_tlt1, r_tlt2, r_tlt_q;
    logic                 r_org1, r_org2, r_org_q;
    logic [32:0]          r_prod;
    logic [COST_W-1:0]    r_cost;
    logic [17:0]          cost_w;

    always_comb begin
        {fneg, forg} = r_fl[CORDIC_STAGES-1];
        pan_a  = fneg ? PI_A - clamp_q(pan_z[CORDIC_STAGES]) : clamp_q(pan_z[CORDIC_STAGES]);
        tilt_a = clamp_q(tlt_z[CORDIC_STAGES]);
        pan_w  = ang_out(pan_a);
        tilt_w = forg ? 32'd0 : ang_out(tilt_a);
        pan_o  = (pan_w > 32'(PAN_MAX)) ? PAN_MAX : pan_w[PAN_W-1:0];
        tilt_o = (tilt_w > 32'(TILT_MAX)) ? TILT_MAX : tilt_w[TILT_W-1:0];
        // inside half the tolerance the angle costs nothing
        ep = (pan_o < (r_tol_pan >> 1)) ? '0 : pan_o - (r_tol_pan >> 1);
        et = (PAN_W'(tilt_o) < (r_tol_tilt >> 1)) ? '0
           : PAN_W'(tilt_o) - (r_tol_tilt >> 1);
        cost_w = r_prod[32:15];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_esum  <= ESUM_W'(ep) + ESUM_W'(et);
            r_pan1  <= pan_o;
            r_tlt1  <= tilt_o;
            r_org1  <= forg;
            r_prod  <= 33'(r_esum) * 33'(r_gain);
            r_pan2  <= r_pan1;
            r_tlt2  <= r_tlt1;
            r_org2  <= r_org1;
            r_cost  <= (cost_w > 18'(COST_MAX)) ? COST_MAX : cost_w[COST_W-1:0];
            r_pan_q <= r_pan2;
            r_tlt_q <= r_tlt2;
            r_org_q <= r_org2;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cost       = r_cost;
    assign o_res.pan_angle  = r_pan_q;
    assign o_res.tilt_angle = r_tlt_q;
    assign o_res.at_origin  = r_org_q;

    a_origin_tilt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.at_origin |-> o_res.tilt_angle == '0)
        else $error("origin item with nonzero tilt");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.pan_angle <= PAN_MAX) && (o_res.tilt_angle <= TILT_MAX))
        else $error("angle out of range");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pt.valid && i_pt.ready |=> r_v[0])
        else $error("accepted item lost at chain entry");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_v))
        else $error("valid line moved during stall");

endmodule

// ===== rtl/gvc_sqrt_cell.sv =====
module gvc_sqrt_cell #(
    parameter int B_SHIFT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gvc_pkg::SQ_W-1:0]  i_n,
    input  logic [gvc_pkg::SQ_W-1:0]  i_r,
    output logic [gvc_pkg::SQ_W-1:0]  o_n,
    output logic [gvc_pkg::SQ_W-1:0]  o_r
);
    import gvc_pkg::*;

    localparam logic [SQ_W-1:0] B = SQ_W'(1) << B_SHIFT;

    logic [SQ_W:0]   trial;
    logic [SQ_W-1:0] n_n;
    logic [SQ_W-1:0] n_r;

    always_comb begin
        trial = {1'b0, i_r} + {1'b0, B};
        if ({1'b0, i_n} >= trial) begin
            n_n = i_n - trial[SQ_W-1:0];
            n_r = (i_r >> 1) + B;
        end else begin
            n_n = i_n;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_n <= n_n;
            o_r <= n_r;
        end
    end
endmodule

// ===== rtl/gvc_cordic_cell.sv =====
module gvc_cordic_cell #(
    parameter int STAGE = 0,
    parameter int FRAC  = 13,
    parameter int ZW    = 17
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [gvc_pkg::CW-1:0] i_x,
    input  logic signed [gvc_pkg::CW-1:0] i_y,
    input  logic signed [ZW-1:0]          i_z,
    output logic signed [gvc_pkg::CW-1:0] o_x,
    output logic signed [gvc_pkg::CW-1:0] o_y,
    output logic signed [ZW-1:0]          o_z
);
    import gvc_pkg::*;

    localparam logic signed [ZW-1:0] ANG = ZW'(q30_to_ang(ATAN_Q30[STAGE], FRAC));

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign xs = i_x >>> STAGE;
    assign ys = i_y >>> STAGE;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                o_x <= i_x + ys;
                o_y <= i_y - xs;
                o_z <= i_z + ANG;
            end else begin
                o_x <= i_x - ys;
                o_y <= i_y + xs;
                o_z <= i_z - ANG;
            end
        end
    end
endmodule

// ===== test/tb_gaze_visibility_cost_core.sv =====
`timescale 1ns / 100ps

module tb_gaze_visibility_cost_core;
    import gvc_pkg::*;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [PAN_W-1:0]  pan_angle;
        logic [TILT_W-1:0] tilt_angle;
        logic              at_origin;
    } t_cost_item;

    localparam int STAGES  = 16;
    localparam int ANG_SH  = 30 - (16 - 3);
    localparam int LATENCY = 9 + 27 + STAGES;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    gvc_point_if pt_if ();
    gvc_cost_if  res_if ();

    gaze_visibility_cost_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow copy of the head frame and cost registers
    logic [47:0] rot_row [3];
    logic [47:0] head_pos;
    logic [14:0] tol_pan, tol_tilt;
    logic [15:0] gain;

    t_cost_item expected_costs [$];
    int  mismatches;
    int  results_seen;
    int  points_sent;
    int  origin_hits;
    int  saturated_hits;
    bit  idle_en;
    int  hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint ang_of(longint q30);
        return (q30 + (longint'(1) <<< (ANG_SH - 1))) >>> ANG_SH;
    endfunction

    // first-quadrant vectoring, clamped to [0, pi/2]
    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ang_of(ATAN_Q30[i]);
            end else begin
                x = x - ys; y = y + xs; z = z - ang_of(ATAN_Q30[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > ang_of(HALF_PI_Q30)) z = ang_of(HALF_PI_Q30);
        return z;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b); r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic t_cost_item predict_cost(logic [15:0] px, logic [15:0] py,
                                                logic [15:0] pz);
        logic [15:0] p [3];
        longint d [3], acc [3], loc [3];
        longint ax, ay, az, zp, pan, tilt, ep, et;
        longint unsigned c;
        logic [15:0] ent;
        t_cost_item r;
        p[0] = px; p[1] = py; p[2] = pz;
        for (int j = 0; j < 3; j++)
            d[j] = longint'($signed(p[j])) - longint'($signed(head_pos[47-16*j -: 16]));
        for (int i = 0; i < 3; i++) begin
            acc[i] = 0;
            for (int j = 0; j < 3; j++) begin
                ent = rot_row[j][47-16*i -: 16];
                acc[i] = acc[i] + longint'($signed(ent)) * d[j];
            end
            loc[i] = acc[i] >>> 8;
        end
        r.at_origin = (acc[0] == 0 && acc[1] == 0 && acc[2] == 0);
        ax = loc[0] < 0 ? -loc[0] : loc[0];
        ay = loc[1] < 0 ? -loc[1] : loc[1];
        az = loc[2] < 0 ? -loc[2] : loc[2];
        zp = vector_angle(ax, ay);
        pan = loc[0] < 0 ? ang_of(PI_Q30) - zp : zp;
        if (pan < 0) pan = 0;
        if (pan > 25736) pan = 25736;
        tilt = r.at_origin ? 0 : vector_angle(int_root(ax * ax + ay * ay), az);
        if (tilt > 12868) tilt = 12868;
        ep = pan < longint'(tol_pan >> 1) ? 0 : pan - longint'(tol_pan >> 1);
        et = tilt < longint'(tol_tilt >> 1) ? 0 : tilt - longint'(tol_tilt >> 1);
        c = (longint'(ep + et) * longint'(gain)) >> 15;
        if (c > 65535) c = 65535;
        r.cost       = c[15:0];
        r.pan_angle  = pan[14:0];
        r.tilt_angle = tilt[13:0];
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_cost_item got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = {res_if.cost, res_if.pan_angle, res_if.tilt_angle, res_if.at_origin};
            results_seen++;
            if (expected_costs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item %h", got);
            end else begin
                want = expected_costs.pop_front();
                if (got.at_origin) origin_hits++;
                if (got.cost == 16'hFFFF) saturated_hits++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: cost %0d/%0d pan %0d/%0d tilt %0d/%0d org %b/%b",
                                 results_seen, want.cost, got.cost, want.pan_angle,
                                 got.pan_angle, want.tilt_angle, got.tilt_angle,
                                 want.at_origin, got.at_origin);
                end
            end
        end
    end

    // receiver side: random stall bursts plus a long hold-off on request
    initial begin
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_if.ready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                res_if.ready = 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 17);
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    task automatic send_point(logic [15:0] px, logic [15:0] py, logic [15:0] pz);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            pt_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        pt_if.valid   = 1'b1;
        pt_if.point_x = px;
        pt_if.point_y = py;
        pt_if.point_z = pz;
        do @(posedge i_clk); while (!pt_if.ready);
        expected_costs.insert(expected_costs.size(), predict_cost(px, py, pz));
        points_sent++;
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        pt_if.valid = 1'b0;
        while (expected_costs.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 6'(idx) << 3; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_ROT0: rot_row[0] = value[47:0];
            REG_ROT1: rot_row[1] = value[47:0];
            REG_ROT2: rot_row[2] = value[47:0];
            REG_POS:  head_pos   = value[47:0];
            REG_TPAN: tol_pan    = value[14:0];
            REG_TTLT: tol_tilt   = value[14:0];
            default:  gain       = value[15:0];
        endcase
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 511)) - 16'd256;
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_frame(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                              logic [47:0] pos, logic [14:0] tp, logic [14:0] tt,
                              logic [15:0] g);
        write_reg(REG_ROT0, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | r0);
        write_reg(REG_ROT1, r1);
        write_reg(REG_ROT2, r2);
        write_reg(REG_POS, pos);
        write_reg(REG_TPAN, tp);
        write_reg(REG_TTLT, tt);
        write_reg(REG_GAIN, g);
    endtask

    task automatic test_directed_points();
        // reset frame: identity, head at origin
        send_point(16'd0, 16'd0, 16'd0);
        send_point(16'h8000, 16'd0, 16'd0);
        send_point(16'd0, 16'd0, 16'h7FFF);
        send_point(16'd0, 16'd0, 16'h8000);
        send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h7FFF, 16'h8000, 16'd1);
        send_point(16'd256, 16'd10, 16'd5);
        send_point(16'hFF00, 16'd0, 16'd0);
        send_point(16'd0, 16'd256, 16'd0);
        send_point(16'd0, 16'hFF00, 16'd0);
        send_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_drain();
    endtask

    task automatic test_register_extremes();
        // full-scale negative rotation, far head position, saturating gain
        load_frame(48'h0000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                   48'h7FFF_8000_7FFF, 15'd0, 15'd0, 16'hFFFF);
        send_point(16'h7FFF, 16'h8000, 16'h7FFF);
        send_point(16'h8000, 16'h7FFF, 16'h8000);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h0000, 16'h0000, 16'h0000);
        wait_drain();
        // wide tolerances swallow all tilt and any pan up to 16383, zero gain
        load_frame(48'h0000_0000_0000, 48'h0000_4000_0000, 48'h7FFF_7FFF_7FFF,
                   48'h0100_FF00_0080, 15'h7FFF, 15'd25736, 16'd0);
        send_point(16'h0100, 16'hFF00, 16'h0080);
        send_point(16'h7FFF, 16'h0000, 16'h8000);
        send_point(16'h8000, 16'h1234, 16'h4321);
        wait_drain();
    endtask

    task automatic test_random_configs(int phases, int per_phase);
        logic [15:0] px, py, pz;
        logic [47:0] r0, r1, r2;
        for (int ph = 0; ph < phases; ph++) begin
            if ($urandom_range(0, 2) == 0) begin
                r0 = 48'h4000_0000_0000; r1 = 48'h0000_4000_0000; r2 = 48'h0000_0000_4000;
            end else begin
                r0 = {$urandom, $urandom}; r1 = {$urandom, $urandom};
                r2 = {$urandom, $urandom};
                r0[47:32] = 16'd0;
            end
            load_frame(r0, r1, r2, {rand_coord(), rand_coord(), rand_coord()},
                       $urandom_range(0, 2) == 0 ? 15'($urandom) : 15'($urandom_range(0, 25736)),
                       $urandom_range(0, 2) == 0 ? 15'($urandom) : 15'($urandom_range(0, 25736)),
                       16'($urandom));
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    px = head_pos[47:32]; py = head_pos[31:16]; pz = head_pos[15:0];
                end else if ($urandom_range(0, 3) == 0) begin
                    px = head_pos[47:32] + 16'($urandom_range(0, 15)) - 16'd8;
                    py = head_pos[31:16] + 16'($urandom_range(0, 15)) - 16'd8;
                    pz = head_pos[15:0]  + 16'($urandom_range(0, 15)) - 16'd8;
                end else begin
                    px = rand_coord(); py = rand_coord(); pz = rand_coord();
                end
                send_point(px, py, pz);
            end
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        for (int k = 0; k < 120; k++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        wait_drain();
        for (int k = 0; k < 30; k++)
            send_point(rand_coord(), rand_coord(), rand_coord());
        wait_drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        pt_if.valid = 1'b0; pt_if.point_x = '0; pt_if.point_y = '0; pt_if.point_z = '0;
        rot_row[0] = ROT0_RST; rot_row[1] = ROT1_RST; rot_row[2] = ROT2_RST;
        head_pos = '0; tol_pan = TOL_RST; tol_tilt = TOL_RST; gain = GAIN_RST;
        mismatches = 0; results_seen = 0; points_sent = 0;
        origin_hits = 0; saturated_hits = 0;
        hold_cycles = 0;
        idle_en = 1'b1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_points();
        test_register_extremes();
        test_random_configs(24, 50);
        test_backpressure();
        idle_en = 1'b0;
        test_random_configs(6, 50);

        wait_drain();
        $display("%0d points through %0d frame settings, %0d at head origin, %0d saturated",
                 points_sent, 32, origin_hits, saturated_hits);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && expected_costs.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
